### rtl/grm_pkg.sv
// grm_pkg: shared constants, register index codes and the sine table rule
// for the gated ring modulator; no dependencies
package grm_pkg;

	localparam int CHANNELS_DEF        = 2;
	localparam int SINE_TABLE_BITS_DEF = 10;
	localparam int SAMPLE_BITS_DEF     = 16;

	// coefficient operand of the shared multiplier, signed
	localparam int COEF_W    = 33;
	localparam int CARRIER_W = 16;
	localparam int ROM_W     = 15;
	localparam int MIX_W     = 17;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 32;

	localparam logic [CFG_INDEX_W-1:0] REG_PHASE_STEP    = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_MIX_LEVEL     = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_GATE_THRESHOLD = 2'd2;

	localparam logic [30:0] PHASE_STEP_RST = 31'd8947849;
	localparam logic [15:0] MIX_LEVEL_RST  = 16'd16384;
	localparam logic [14:0] GATE_THR_RST   = 15'd0;

	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	// quarter-wave sine in unsigned q0.15, taylor series to x^11 in q2.30
	function automatic logic [ROM_W-1:0] quarter_sine(input int unsigned r,
			input int unsigned tbits);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] sum;
		logic [63:0] q;
		x    = (64'(r) * HALF_PI_Q30) >> (tbits - 2);
		x2   = (x * x) >> 30;
		term = x;
		sum  = x;
		term = ((term * x2) >> 30) / 64'd6;
		sum  = sum - term;
		term = ((term * x2) >> 30) / 64'd20;
		sum  = sum + term;
		term = ((term * x2) >> 30) / 64'd42;
		sum  = sum - term;
		term = ((term * x2) >> 30) / 64'd72;
		sum  = sum + term;
		term = ((term * x2) >> 30) / 64'd110;
		sum  = sum - term;
		q    = (sum + 64'd16384) >> 15;
		if (q > 64'd32767) begin
			q = 64'd32767;
		end
		return q[ROM_W-1:0];
	endfunction

endpackage

### rtl/gated_ring_modulator.sv
// gated_ring_modulator: sine-carrier ring modulator with gate and dry/wet mix
// an accepted word runs through ROM read, coefficient, then multiply and round per channel, to m_tvalid
// a new frame is taken only once the last one is in the output register, as the one multiplier is
// used once for carrier times mix and once per channel
// reset: arst_n clears phase, sequencer and output valid flag and loads register defaults
// depends on grm_pkg, grm_sine_rom and grm_mac
module gated_ring_modulator #(
	parameter int CHANNELS        = grm_pkg::CHANNELS_DEF,
	parameter int SINE_TABLE_BITS = grm_pkg::SINE_TABLE_BITS_DEF,
	parameter int SAMPLE_BITS     = grm_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	// sample_ch0, sample_ch1, ... from bit 0 up, zero padding on top
	input  logic [((CHANNELS*SAMPLE_BITS+7)/8)*8-1:0] s_tdata,
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	// out_ch0, out_ch1, ... from bit 0 up, zero padding on top
	output logic [((CHANNELS*SAMPLE_BITS+7)/8)*8-1:0] m_tdata,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [grm_pkg::CFG_INDEX_W-1:0]        cfg_index,
	input  logic [grm_pkg::CFG_DATA_W-1:0]         cfg_data
);

	localparam int SB     = SAMPLE_BITS;
	localparam int IN_W   = CHANNELS * SB;
	localparam int TD_W   = ((IN_W + 7) / 8) * 8;
	localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int OPB_W  = (SB > 18) ? SB : 18;
	localparam int PW     = grm_pkg::COEF_W + OPB_W;
	localparam int YW     = PW - 29;
	localparam int TB     = SINE_TABLE_BITS;
	localparam int CW     = grm_pkg::COEF_W;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_ROM  = 3'd1;
	localparam logic [2:0] S_COEF = 3'd2;
	localparam logic [2:0] S_MAC  = 3'd3;
	localparam logic [2:0] S_RND  = 3'd4;
	localparam logic [2:0] S_DONE = 3'd5;

	localparam logic [PW:0] RND_BIAS = (PW+1)'(64'd1 << 29);
	localparam logic signed [YW-1:0] SAT_MAX = YW'((64'd1 << (SB - 1)) - 64'd1);
	localparam logic signed [YW-1:0] SAT_MIN = ~SAT_MAX;
	localparam logic [TB-2:0] QUARTER_ADDR = (TB-1)'(1 << (TB - 2));

	logic [2:0]  state_q;
	logic [31:0] phase_q;
	logic [30:0] phase_step_q;
	logic [15:0] mix_level_q;
	logic [14:0] gate_thr_q;

	logic [CH_W-1:0]   ch_q;
	logic [SB-1:0]     samp_q [CHANNELS];
	logic [CHANNELS-1:0] gate_open_q;
	logic [SB-1:0]     res_q [CHANNELS];
	logic              neg_q;
	logic signed [CW-1:0] coef_q;
	logic              m_tvalid_q;
	logic [TD_W-1:0]   m_tdata_q;

	logic                 accept;
	logic [TB-1:0]        rom_idx;
	logic [TB-2:0]        rom_addr;
	logic [grm_pkg::ROM_W-1:0] rom_data;
	logic signed [grm_pkg::CARRIER_W-1:0] carrier;
	logic [grm_pkg::MIX_W-1:0] mix_sat;
	logic [grm_pkg::MIX_W-1:0] dry;
	logic signed [CW-1:0] dry_coef;
	logic signed [CW-1:0] opa;
	logic signed [OPB_W-1:0] opb;
	logic                 mac_en;
	logic signed [PW-1:0] prod;
	logic [PW:0]          rsum;
	logic signed [YW-1:0] y_w;
	logic [SB-1:0]        y_sat;
	logic [CHANNELS-1:0]  gate_open_w;
	logic [IN_W-1:0]      res_flat;
	logic                 out_load;

	assign accept    = s_tvalid && s_tready;
	assign s_tready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;

	// quarter-wave addressing: odd quadrants run the table backwards
	assign rom_idx  = phase_q[31 -: TB];
	assign rom_addr = rom_idx[TB-2] ? (QUARTER_ADDR - {1'b0, rom_idx[TB-3:0]})
	                                : {1'b0, rom_idx[TB-3:0]};

	grm_sine_rom #(
		.SINE_TABLE_BITS(SINE_TABLE_BITS)
	) u_rom (
		.clk  (clk),
		.rd_en(accept),
		.addr (rom_addr),
		.data (rom_data)
	);

	assign carrier  = neg_q ? -$signed({1'b0, rom_data}) : $signed({1'b0, rom_data});
	assign mix_sat  = (mix_level_q > 16'd32768) ? 17'd32768 : {1'b0, mix_level_q};
	assign dry      = 17'd32768 - mix_sat;
	assign dry_coef = $signed({1'b0, dry, 15'b0});

	// gated channels keep only the dry part
	always_comb begin
		if (state_q == S_ROM) begin
			opa = CW'(carrier);
			opb = OPB_W'({1'b0, mix_sat});
		end else begin
			opa = gate_open_q[ch_q] ? coef_q : dry_coef;
			opb = OPB_W'($signed(samp_q[ch_q]));
		end
	end

	assign mac_en = (state_q == S_ROM) || (state_q == S_MAC);

	grm_mac #(
		.OPB_W(OPB_W)
	) u_mac (
		.clk (clk),
		.en  (mac_en),
		.opa (opa),
		.opb (opb),
		.prod(prod)
	);

	// round half up from q30 and saturate to the sample range
	assign rsum = {prod[PW-1], prod} + RND_BIAS;
	assign y_w  = $signed(rsum[PW:30]);
	assign y_sat = (y_w > SAT_MAX) ? SAT_MAX[SB-1:0] :
	               (y_w < SAT_MIN) ? SAT_MIN[SB-1:0] : y_w[SB-1:0];

	always_comb begin
		logic [SB-1:0] smp;
		logic [SB-1:0] mag;
		smp = '0;
		mag = '0;
		for (int c = 0; c < CHANNELS; c++) begin
			smp = s_tdata[c*SB +: SB];
			mag = smp[SB-1] ? (~smp + 1'b1) : smp;
			gate_open_w[c] = ({mag, 15'b0}) >= (SB+15)'({gate_thr_q, {(SB-1){1'b0}}});
		end
	end

	always_comb begin
		for (int c = 0; c < CHANNELS; c++) begin
			res_flat[c*SB +: SB] = res_q[c];
		end
	end

	assign out_load = (state_q == S_DONE) && (!m_tvalid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_step_q <= grm_pkg::PHASE_STEP_RST;
			mix_level_q  <= grm_pkg::MIX_LEVEL_RST;
			gate_thr_q   <= grm_pkg::GATE_THR_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				grm_pkg::REG_PHASE_STEP: begin
					phase_step_q <= cfg_data[30:0];
				end
				grm_pkg::REG_MIX_LEVEL: begin
					mix_level_q <= cfg_data[15:0];
				end
				grm_pkg::REG_GATE_THRESHOLD: begin
					gate_thr_q <= cfg_data[14:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			phase_q    <= '0;
			ch_q       <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						// carrier is read before the phase moves on
						phase_q <= phase_q + {1'b0, phase_step_q};
						state_q <= S_ROM;
					end
				end
				S_ROM: begin
					state_q <= S_COEF;
				end
				S_COEF: begin
					ch_q    <= '0;
					state_q <= S_MAC;
				end
				S_MAC: begin
					state_q <= S_RND;
				end
				S_RND: begin
					if (ch_q == CH_W'(CHANNELS - 1)) begin
						state_q <= S_DONE;
					end else begin
						ch_q    <= ch_q + 1'b1;
						state_q <= S_MAC;
					end
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			for (int c = 0; c < CHANNELS; c++) begin
				samp_q[c] <= s_tdata[c*SB +: SB];
			end
			gate_open_q <= gate_open_w;
			neg_q       <= rom_idx[TB-1];
		end
		if (state_q == S_COEF) begin
			coef_q <= prod[CW-1:0] + dry_coef;
		end
		if (state_q == S_RND) begin
			res_q[ch_q] <= y_sat;
		end
		if (out_load) begin
			m_tdata_q <= TD_W'(res_flat);
		end
	end

	a_phase_advance: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> phase_q == ($past(phase_q) + {1'b0, $past(phase_step_q)}))
		else $error("phase did not advance by one step on an accepted word");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !s_tready)
		else $error("input taken while a frame is in work");

	a_hold_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && m_tvalid_q && !m_tready) |=> state_q == S_DONE)
		else $error("result left done state while output register was full");

	a_ch_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MAC || state_q == S_RND) |-> ch_q <= CH_W'(CHANNELS - 1))
		else $error("channel counter out of range");

	a_ch_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_COEF) |=> (state_q == S_MAC && ch_q == '0))
		else $error("channel loop did not start at channel zero");

endmodule

### rtl/grm_sine_rom.sv
// grm_sine_rom: quarter-wave sine table with registered read data
// depends on grm_pkg for the table rule
module grm_sine_rom #(
	parameter int SINE_TABLE_BITS = grm_pkg::SINE_TABLE_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         rd_en,
	input  logic [SINE_TABLE_BITS-2:0]   addr,
	output logic [grm_pkg::ROM_W-1:0]    data
);

	localparam int QUARTER = 1 << (SINE_TABLE_BITS - 2);

	logic [grm_pkg::ROM_W-1:0] rom_w [QUARTER+1];
	logic [grm_pkg::ROM_W-1:0] data_q;

	// entries are constants worked out at elaboration
	for (genvar i = 0; i <= QUARTER; i++) begin : g_entry
		assign rom_w[i] = grm_pkg::quarter_sine(i, SINE_TABLE_BITS);
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			data_q <= rom_w[addr];
		end
	end

	assign data = data_q;

endmodule

### rtl/grm_mac.sv
// grm_mac: the shared signed multiplier with its product register
// depends on grm_pkg for the coefficient width
module grm_mac #(
	parameter int OPB_W = 18
) (
	input  logic                                 clk,
	input  logic                                 en,
	input  logic signed [grm_pkg::COEF_W-1:0]    opa,
	input  logic signed [OPB_W-1:0]              opb,
	output logic signed [grm_pkg::COEF_W+OPB_W-1:0] prod
);

	logic signed [grm_pkg::COEF_W+OPB_W-1:0] prod_q;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= opa * opb;
		end
	end

	assign prod = prod_q;

endmodule
